[src/pfne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfne_pkg
// Types and constants shared by the parallel fault netlist evaluator.
// ----------------------------------------------------------------------------
package pfne_pkg;

	localparam int NODE_COUNT  = 1024;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int MAX_FANIN   = 4;
	localparam int FANIN_SLOTS = 4;
	localparam int FANIN_LIMIT = (MAX_FANIN < FANIN_SLOTS) ? MAX_FANIN : FANIN_SLOTS;
	localparam int LANE_COUNT  = 64;

	localparam logic [63:0] LANE_MASK = {64{1'b1}} >> (64 - LANE_COUNT);

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [1:0] ST_NO_FANIN = 2'd2;

	localparam logic [1:0] VAL_UNKNOWN = 2'd2;

	localparam logic [1:0] FM_STUCK1 = 2'd0;
	localparam logic [1:0] FM_STUCK0 = 2'd1;
	localparam logic [1:0] FM_FLIP   = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [9:0]  node_index;
		logic [2:0]  fanin_count;
		logic [9:0]  fanin_a;
		logic [9:0]  fanin_b;
		logic [9:0]  fanin_c;
		logic [9:0]  fanin_d;
		logic [15:0] cell_table;
		logic        golden_bit;
		logic [63:0] lane_flags;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  node_value;
		logic [63:0] node_lanes;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [2:0]                          cnt;
		logic [FANIN_SLOTS-1:0][NODE_W-1:0]  fanin;
		logic [15:0]                         truth;
	} node_entry_t;

	typedef struct packed {
		logic [1:0]  val;
		logic [63:0] lanes;
	} node_state_t;

endpackage

[src/parallel_fault_netlist_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_fault_netlist_evaluator
// 64-lane parallel fault simulator over a node table held in two memories.
// ----------------------------------------------------------------------------
//  channel   signals                     transaction when
//  command   start, busy, cmd            start & !busy at rising edge
//  result    done, rsp                   done high (one cycle, no back-pressure)
//  config    cfg_valid, cfg_ready, cfg_data   cfg_valid & cfg_ready
//
// Load and set answer from idle and read from a read state. An evaluate
// reads the node memory, then the state memory once per fanin, then computes;
// a node without fanins ends at the node read. The single read port of the
// state memory sets the evaluate length. After reset a clearing pass writes
// every state entry to unknown / zero lanes while busy is high;
// configuration writes are taken throughout. Results cannot be stalled.
// ----------------------------------------------------------------------------
module parallel_fault_netlist_evaluator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pfne_pkg::cmd_t cmd,
	output logic           done,
	output pfne_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_data
);
	import pfne_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_NODE, S_FAN, S_CALC
	} state_t;

	state_t                state_q;
	logic [NODE_W-1:0]     clr_q;
	logic [NODE_W-1:0]     node_q;
	logic [2:0]            k_q;
	node_entry_t           ent_q;
	node_state_t           own_q;
	node_state_t [FANIN_SLOTS-1:0] fan_q;
	logic [1:0]            perturb_mode_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	// memories
	node_entry_t           node_mem [NODE_COUNT];
	node_state_t           st_mem   [NODE_COUNT];
	node_entry_t           node_rd_q;
	node_state_t           st_rd_q;

	logic                  accept;
	logic                  node_we, node_re, st_we, st_re;
	logic [NODE_W-1:0]     st_raddr, st_waddr;
	node_state_t           st_wdata;
	node_entry_t           node_wdata;
	logic [2:0]            load_cnt;

	// evaluate datapath
	logic                  unk;
	logic [3:0]            idx;
	logic                  gold;
	logic [63:0]           marks;
	logic [FANIN_SLOTS-1:0] slot_used;
	logic [FANIN_SLOTS-1:0][63:0] fl;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// saturate the fanin count on load
	assign load_cnt = (cmd.fanin_count > 3'(FANIN_LIMIT)) ? 3'(FANIN_LIMIT) : cmd.fanin_count;

	always_comb begin
		node_wdata.cnt      = load_cnt;
		node_wdata.fanin[0] = cmd.fanin_a;
		node_wdata.fanin[1] = cmd.fanin_b;
		node_wdata.fanin[2] = cmd.fanin_c;
		node_wdata.fanin[3] = cmd.fanin_d;
		node_wdata.truth    = cmd.cell_table;
	end

	assign node_we = accept && (cmd.opcode == OP_LOAD);
	assign node_re = accept && (cmd.opcode == OP_EVAL);

	// state memory port control
	always_comb begin
		st_re    = 1'b0;
		st_raddr = cmd.node_index;
		st_we    = 1'b0;
		st_waddr = cmd.node_index;
		st_wdata = '{val: VAL_UNKNOWN, lanes: 64'd0};
		unique case (state_q)
			S_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.opcode)
						OP_LOAD: st_we = 1'b1;
						OP_SET: begin
							st_we    = 1'b1;
							st_wdata = '{val: {1'b0, cmd.golden_bit},
								lanes: cmd.lane_flags & LANE_MASK};
						end
						OP_EVAL, OP_READ: st_re = 1'b1;
						default: st_re = 1'b0;
					endcase
				end
			end
			S_FAN: begin
				st_raddr = ent_q.fanin[k_q[1:0]];
				st_re    = (k_q < ent_q.cnt);
			end
			S_CALC: begin
				st_we    = !unk;
				st_waddr = node_q;
				st_wdata = '{val: {1'b0, gold}, lanes: (own_q.lanes | marks) & LANE_MASK};
			end
			default: st_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[cmd.node_index] <= node_wdata;
		if (node_re)
			node_rd_q <= node_mem[cmd.node_index];
	end

	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= st_wdata;
		if (st_re)
			st_rd_q <= st_mem[st_raddr];
	end

	// golden lookup and per-lane perturbation
	always_comb begin
		unk = 1'b0;
		idx = 4'd0;
		for (int j = 0; j < FANIN_SLOTS; j++) begin
			slot_used[j] = (3'(j) < ent_q.cnt);
			fl[j]        = slot_used[j] ? (fan_q[j].lanes & LANE_MASK) : 64'd0;
			if (slot_used[j] && (fan_q[j].val > 2'd1))
				unk = 1'b1;
			idx[j] = slot_used[j] & fan_q[j].val[0];
		end
		gold = ent_q.truth[idx];
	end

	always_comb begin
		for (int l = 0; l < 64; l++) begin
			logic [3:0] m;
			logic [3:0] pidx;
			m = {fl[3][l], fl[2][l], fl[1][l], fl[0][l]};
			unique case (perturb_mode_q)
				FM_STUCK1: pidx = idx | m;
				FM_STUCK0: pidx = idx & ~m;
				FM_FLIP:   pidx = idx ^ m;
				default:   pidx = idx;
			endcase
			marks[l] = (|m) && (ent_q.truth[pidx] != gold);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			perturb_mode_q <= FM_FLIP;
		else if (cfg_valid && cfg_ready)
			perturb_mode_q <= cfg_data;
	end

	// sequencer: one command at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			k_q     <= 3'd0;
			node_q  <= '0;
			ent_q   <= '0;
			own_q   <= '0;
			fan_q   <= '0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// sweep the state memory to its reset value
					clr_q <= clr_q + 1'b1;
					if (clr_q == {NODE_W{1'b1}})
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						node_q <= cmd.node_index;
						unique case (cmd.opcode)
							OP_LOAD: begin
								done_q <= 1'b1;
								rsp_q  <= '{node_value: VAL_UNKNOWN, node_lanes: 64'd0,
									status: ST_OK};
							end
							OP_SET: begin
								done_q <= 1'b1;
								rsp_q  <= '{node_value: {1'b0, cmd.golden_bit},
									node_lanes: cmd.lane_flags & LANE_MASK, status: ST_OK};
							end
							OP_READ: state_q <= S_READ;
							OP_EVAL: state_q <= S_NODE;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					rsp_q   <= '{node_value: st_rd_q.val, node_lanes: st_rd_q.lanes,
						status: ST_OK};
					state_q <= S_IDLE;
				end
				S_NODE: begin
					ent_q <= node_rd_q;
					own_q <= st_rd_q;
					k_q   <= 3'd0;
					if (node_rd_q.cnt == 3'd0) begin
						// undriven node: report and leave it untouched
						done_q  <= 1'b1;
						rsp_q   <= '{node_value: st_rd_q.val, node_lanes: st_rd_q.lanes,
							status: ST_NO_FANIN};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FAN;
					end
				end
				S_FAN: begin
					// capture the fanin read issued last cycle
					if (k_q != 3'd0)
						fan_q[2'(k_q - 3'd1)] <= st_rd_q;
					if (k_q == ent_q.cnt)
						state_q <= S_CALC;
					else
						k_q <= k_q + 3'd1;
				end
				S_CALC: begin
					done_q <= 1'b1;
					if (unk)
						rsp_q <= '{node_value: own_q.val, node_lanes: own_q.lanes,
							status: ST_UNKNOWN};
					else
						rsp_q <= '{node_value: {1'b0, gold},
							node_lanes: (own_q.lanes | marks) & LANE_MASK, status: ST_OK};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
